// ===== rtl/hrhp_pkg.sv =====
// ============================================================================
// HTTP request head parser package
// Payload types, phase codes, status and role codes, and character classes
// shared by the parser and its ports.
// ============================================================================
package hrhp_pkg;

    // Input payload: one byte of the request head and a restart flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in;

    // Result payload: one per input byte.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_role;
        logic [7:0] echo_byte;
        logic [7:0] major_version;
        logic [7:0] minor_version;
    } t_out;

    localparam int PH_BITS = 5;

    // Parse phase codes. Codes 20 to 31 are unused and reject every byte.
    localparam logic [PH_BITS-1:0] PH_METHOD_START = 5'd0;
    localparam logic [PH_BITS-1:0] PH_METHOD       = 5'd1;
    localparam logic [PH_BITS-1:0] PH_URI          = 5'd2;
    localparam logic [PH_BITS-1:0] PH_VER_H        = 5'd3;
    localparam logic [PH_BITS-1:0] PH_VER_T1       = 5'd4;
    localparam logic [PH_BITS-1:0] PH_VER_T2       = 5'd5;
    localparam logic [PH_BITS-1:0] PH_VER_P        = 5'd6;
    localparam logic [PH_BITS-1:0] PH_VER_SLASH    = 5'd7;
    localparam logic [PH_BITS-1:0] PH_MAJOR_START  = 5'd8;
    localparam logic [PH_BITS-1:0] PH_MAJOR        = 5'd9;
    localparam logic [PH_BITS-1:0] PH_MINOR_START  = 5'd10;
    localparam logic [PH_BITS-1:0] PH_MINOR        = 5'd11;
    localparam logic [PH_BITS-1:0] PH_LF1          = 5'd12;
    localparam logic [PH_BITS-1:0] PH_LINE_START   = 5'd13;
    localparam logic [PH_BITS-1:0] PH_LWS          = 5'd14;
    localparam logic [PH_BITS-1:0] PH_HNAME        = 5'd15;
    localparam logic [PH_BITS-1:0] PH_SPACE_BEFORE = 5'd16;
    localparam logic [PH_BITS-1:0] PH_HVALUE       = 5'd17;
    localparam logic [PH_BITS-1:0] PH_LF2          = 5'd18;
    localparam logic [PH_BITS-1:0] PH_LF3          = 5'd19;

    // Status codes.
    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_GOOD = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Byte role codes.
    localparam logic [2:0] RO_NONE   = 3'd0;
    localparam logic [2:0] RO_METHOD = 3'd1;
    localparam logic [2:0] RO_URI    = 3'd2;
    localparam logic [2:0] RO_HSTART = 3'd3;
    localparam logic [2:0] RO_HNAME  = 3'd4;
    localparam logic [2:0] RO_HVALUE = 3'd5;

    // Characters.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_US    = 8'h1F;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CH_US) || (c == CH_DEL);
    endfunction

    function automatic logic is_tspecial(input logic [7:0] c);
        return c inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, CH_COLON,
                         8'h5C, 8'h22, CH_SLASH, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
                         8'h7B, 8'h7D, CH_SP, CH_HT};
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_tspecial(c);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== rtl/http_request_head_parser_unit.sv =====
// ============================================================================
// HTTP request head parser unit
// Walks an HTTP/1.x request line and header block one byte at a time and
// tags every byte with a status, a field role and the version so far.
// ============================================================================
//
//  Channel   Valid        Stall        Payload                  Direction
//  -------   ----------   ----------   ----------------------   ---------
//  request   i_valid      o_stall      i_req (hrhp_pkg::t_in)   in
//  result    o_valid      i_stall      o_res (hrhp_pkg::t_out)  out
//
// A request taken at a clock edge is parsed by the logic between the input
// and result registers and shows up as a valid result when the result register
// loads it; with no stall, one request is taken and one result leaves every cycle.
// Reset (i_rst_n low at a clock edge) empties both registers and clears the
// parser state. A stalled result holds while the input register takes one
// more request; o_stall rises only when both registers are full.

module http_request_head_parser_unit #(
    parameter int VERSION_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hrhp_pkg::t_in   i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output hrhp_pkg::t_out  o_res
);

    localparam int                  VW   = VERSION_BITS;
    localparam logic [VW+3:0]       VMAX = {4'b0000, {VW{1'b1}}};

    // Pipeline registers.
    logic            r_in_valid;
    hrhp_pkg::t_in   r_in;
    logic            r_out_valid;
    hrhp_pkg::t_out  r_out;

    // Parser state.
    logic [hrhp_pkg::PH_BITS-1:0] r_phase;
    logic                         r_seen;
    logic [VW-1:0]                r_major;
    logic [VW-1:0]                r_minor;

    logic [hrhp_pkg::PH_BITS-1:0] n_phase;
    logic                         n_seen;
    logic [VW-1:0]                n_major;
    logic [VW-1:0]                n_minor;
    hrhp_pkg::t_out               n_out;

    // State as seen by this byte, after an optional restart.
    logic [hrhp_pkg::PH_BITS-1:0] b_phase;
    logic                         b_seen;
    logic [VW-1:0]                b_major;
    logic [VW-1:0]                b_minor;

    // Working values of the byte's parse before the malformed check.
    logic [hrhp_pkg::PH_BITS-1:0] w_phase;
    logic                         w_seen;
    logic [VW-1:0]                w_major;
    logic [VW-1:0]                w_minor;
    logic [1:0]                   w_status;
    logic [2:0]                   w_role;

    logic [7:0]    c;
    logic [3:0]    digit;
    logic [VW-1:0] major_step;
    logic [VW-1:0] minor_step;
    logic [VW+7:0] major_ext;
    logic [VW+7:0] minor_ext;
    logic          advance;

    // Decimal accumulate with saturation at the all-ones version value.
    function automatic logic [VW-1:0] accum(input logic [VW-1:0] v, input logic [3:0] d);
        logic [VW+3:0] wide;
        wide = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + {{VW{1'b0}}, d};
        return (wide > VMAX) ? {VW{1'b1}} : wide[VW-1:0];
    endfunction

    // The result register moves when it is empty or being taken.
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    assign c     = r_in.data_byte;
    assign digit = c[3:0];

    always_comb begin
        if (r_in.restart) begin
            b_phase = hrhp_pkg::PH_METHOD_START;
            b_seen  = 1'b0;
            b_major = '0;
            b_minor = '0;
        end else begin
            b_phase = r_phase;
            b_seen  = r_seen;
            b_major = r_major;
            b_minor = r_minor;
        end
    end

    assign major_step = accum(b_major, digit);
    assign minor_step = accum(b_minor, digit);

    always_comb begin
        w_phase  = b_phase;
        w_seen   = b_seen;
        w_major  = b_major;
        w_minor  = b_minor;
        w_status = hrhp_pkg::ST_MORE;
        w_role   = hrhp_pkg::RO_NONE;
        case (b_phase)
            hrhp_pkg::PH_METHOD_START: begin
                if (hrhp_pkg::is_token(c)) begin
                    w_phase = hrhp_pkg::PH_METHOD;
                    w_role  = hrhp_pkg::RO_METHOD;
                end else begin
                    w_status = hrhp_pkg::ST_BAD;
                end
            end
            hrhp_pkg::PH_METHOD: begin
                if (c == hrhp_pkg::CH_SP) w_phase = hrhp_pkg::PH_URI;
                else if (hrhp_pkg::is_token(c)) w_role = hrhp_pkg::RO_METHOD;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_URI: begin
                if (c == hrhp_pkg::CH_SP) w_phase = hrhp_pkg::PH_VER_H;
                else if (hrhp_pkg::is_ctl(c)) w_status = hrhp_pkg::ST_BAD;
                else w_role = hrhp_pkg::RO_URI;
            end
            hrhp_pkg::PH_VER_H: begin
                if (c == hrhp_pkg::CH_H) w_phase = hrhp_pkg::PH_VER_T1;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VER_T1: begin
                if (c == hrhp_pkg::CH_T) w_phase = hrhp_pkg::PH_VER_T2;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VER_T2: begin
                if (c == hrhp_pkg::CH_T) w_phase = hrhp_pkg::PH_VER_P;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VER_P: begin
                if (c == hrhp_pkg::CH_P) w_phase = hrhp_pkg::PH_VER_SLASH;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VER_SLASH: begin
                if (c == hrhp_pkg::CH_SLASH) begin
                    w_major = '0;
                    w_minor = '0;
                    w_phase = hrhp_pkg::PH_MAJOR_START;
                end else begin
                    w_status = hrhp_pkg::ST_BAD;
                end
            end
            hrhp_pkg::PH_MAJOR_START: begin
                if (hrhp_pkg::is_digit(c)) begin
                    w_major = major_step;
                    w_phase = hrhp_pkg::PH_MAJOR;
                end else begin
                    w_status = hrhp_pkg::ST_BAD;
                end
            end
            hrhp_pkg::PH_MAJOR: begin
                if (c == hrhp_pkg::CH_DOT) w_phase = hrhp_pkg::PH_MINOR_START;
                else if (hrhp_pkg::is_digit(c)) w_major = major_step;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_MINOR_START: begin
                if (hrhp_pkg::is_digit(c)) begin
                    w_minor = minor_step;
                    w_phase = hrhp_pkg::PH_MINOR;
                end else begin
                    w_status = hrhp_pkg::ST_BAD;
                end
            end
            hrhp_pkg::PH_MINOR: begin
                if (c == hrhp_pkg::CH_CR) w_phase = hrhp_pkg::PH_LF1;
                else if (hrhp_pkg::is_digit(c)) w_minor = minor_step;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_LF1: begin
                if (c == hrhp_pkg::CH_LF) w_phase = hrhp_pkg::PH_LINE_START;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_LINE_START: begin
                // Leading whitespace folds onto the previous header only
                // once a header has been seen.
                if (c == hrhp_pkg::CH_CR) begin
                    w_phase = hrhp_pkg::PH_LF3;
                end else if (b_seen && (c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_HT)) begin
                    w_phase = hrhp_pkg::PH_LWS;
                end else if (hrhp_pkg::is_token(c)) begin
                    w_seen  = 1'b1;
                    w_role  = hrhp_pkg::RO_HSTART;
                    w_phase = hrhp_pkg::PH_HNAME;
                end else begin
                    w_status = hrhp_pkg::ST_BAD;
                end
            end
            hrhp_pkg::PH_LWS: begin
                if (c == hrhp_pkg::CH_CR) begin
                    w_phase = hrhp_pkg::PH_LF2;
                end else if (c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_HT) begin
                    w_phase = hrhp_pkg::PH_LWS;
                end else if (hrhp_pkg::is_ctl(c)) begin
                    w_status = hrhp_pkg::ST_BAD;
                end else begin
                    w_role  = hrhp_pkg::RO_HVALUE;
                    w_phase = hrhp_pkg::PH_HVALUE;
                end
            end
            hrhp_pkg::PH_HNAME: begin
                if (c == hrhp_pkg::CH_COLON) w_phase = hrhp_pkg::PH_SPACE_BEFORE;
                else if (hrhp_pkg::is_token(c)) w_role = hrhp_pkg::RO_HNAME;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_SPACE_BEFORE: begin
                if (c == hrhp_pkg::CH_SP) w_phase = hrhp_pkg::PH_HVALUE;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_HVALUE: begin
                if (c == hrhp_pkg::CH_CR) w_phase = hrhp_pkg::PH_LF2;
                else if (hrhp_pkg::is_ctl(c)) w_status = hrhp_pkg::ST_BAD;
                else w_role = hrhp_pkg::RO_HVALUE;
            end
            hrhp_pkg::PH_LF2: begin
                if (c == hrhp_pkg::CH_LF) w_phase = hrhp_pkg::PH_LINE_START;
                else w_status = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_LF3: begin
                // The head is done; the phase parks here until a restart.
                w_status = (c == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_GOOD : hrhp_pkg::ST_BAD;
            end
            default: begin
                w_status = hrhp_pkg::ST_BAD;
            end
        endcase
    end

    // A malformed byte leaves the state as it stood after any restart.
    always_comb begin
        if (w_status == hrhp_pkg::ST_BAD) begin
            n_phase = b_phase;
            n_seen  = b_seen;
            n_major = b_major;
            n_minor = b_minor;
        end else begin
            n_phase = w_phase;
            n_seen  = w_seen;
            n_major = w_major;
            n_minor = w_minor;
        end
    end

    assign major_ext = {8'h00, n_major};
    assign minor_ext = {8'h00, n_minor};

    always_comb begin
        n_out.status        = w_status;
        n_out.byte_role     = w_role;
        n_out.echo_byte     = c;
        n_out.major_version = major_ext[7:0];
        n_out.minor_version = minor_ext[7:0];
    end

    // Input register: loads whenever it is not holding a blocked request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_in <= i_req;
        end
    end

    // Result register and parser state move together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= hrhp_pkg::PH_METHOD_START;
            r_seen      <= 1'b0;
            r_major     <= '0;
            r_minor     <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_phase <= n_phase;
                r_seen  <= n_seen;
                r_major <= n_major;
                r_minor <= n_minor;
            end
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // A malformed byte never carries a field role.
    a_bad_no_role : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == hrhp_pkg::ST_BAD) |-> (o_res.byte_role == hrhp_pkg::RO_NONE))
        else $error("malformed result carries a byte role");

    // A complete head leaves the parser parked after the closing CR.
    a_good_parks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == hrhp_pkg::ST_GOOD) |-> (r_phase == hrhp_pkg::PH_LF3))
        else $error("complete status without parked phase");

    // The echoed byte is the one that moved out of the input register.
    a_echo : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid) |=> (o_res.echo_byte == $past(r_in.data_byte)))
        else $error("echoed byte does not match parsed byte");

    // A waiting input request is held only while the result side is blocked.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && r_in_valid))
        else $error("input stalled with a free pipeline slot");

endmodule

// ===== tb/hrhp_result_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// HTTP request head parser result checker
// Watches both channels of the parser, predicts the result of every accepted
// request byte and compares each accepted result with the oldest prediction.
// ============================================================================
module hrhp_result_checker #(
    parameter int VERSION_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_stall,
    input  hrhp_pkg::t_in  i_req,
    input  logic           i_res_valid,
    input  logic           i_res_stall,
    input  hrhp_pkg::t_out i_res,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int VER_MAX = (1 << VERSION_BITS) - 1;

    // Predicted parser state.
    logic [hrhp_pkg::PH_BITS-1:0] phase;
    logic                         hdr_seen;
    int                           major_acc;
    int                           minor_acc;

    hrhp_pkg::t_out expected_results[$];
    hrhp_pkg::t_out oldest;

    function automatic logic ctl_char(input logic [7:0] c);
        return (c <= hrhp_pkg::CH_US) || (c == hrhp_pkg::CH_DEL);
    endfunction

    function automatic logic sep_char(input logic [7:0] c);
        case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, hrhp_pkg::CH_COLON,
            8'h5C, 8'h22, hrhp_pkg::CH_SLASH, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
            8'h7B, 8'h7D, hrhp_pkg::CH_SP, hrhp_pkg::CH_HT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic tok_char(input logic [7:0] c);
        return (c < 8'h80) && !ctl_char(c) && !sep_char(c);
    endfunction

    function automatic logic dig_char(input logic [7:0] c);
        return (c >= hrhp_pkg::CH_ZERO) && (c <= hrhp_pkg::CH_NINE);
    endfunction

    function automatic int add_digit(input int v, input logic [7:0] c);
        int n;
        n = v * 10 + (int'(c) - int'(hrhp_pkg::CH_ZERO));
        return (n > VER_MAX) ? VER_MAX : n;
    endfunction

    // Advances the predicted state by one byte and returns its result.
    function automatic hrhp_pkg::t_out predict_byte(input hrhp_pkg::t_in req);
        logic [7:0]                   c;
        logic [1:0]                   st;
        logic [2:0]                   role;
        logic [hrhp_pkg::PH_BITS-1:0] nxt;
        hrhp_pkg::t_out               r;
        c    = req.data_byte;
        st   = hrhp_pkg::ST_MORE;
        role = hrhp_pkg::RO_NONE;
        if (req.restart) begin
            phase     = hrhp_pkg::PH_METHOD_START;
            hdr_seen  = 1'b0;
            major_acc = 0;
            minor_acc = 0;
        end
        nxt = phase;
        case (phase)
            hrhp_pkg::PH_METHOD_START: begin
                if (tok_char(c)) begin
                    nxt  = hrhp_pkg::PH_METHOD;
                    role = hrhp_pkg::RO_METHOD;
                end else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_METHOD: begin
                if (c == hrhp_pkg::CH_SP) nxt = hrhp_pkg::PH_URI;
                else if (tok_char(c)) role = hrhp_pkg::RO_METHOD;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_URI: begin
                if (c == hrhp_pkg::CH_SP) nxt = hrhp_pkg::PH_VER_H;
                else if (ctl_char(c)) st = hrhp_pkg::ST_BAD;
                else role = hrhp_pkg::RO_URI;
            end
            hrhp_pkg::PH_VER_H: begin
                if (c == hrhp_pkg::CH_H) nxt = hrhp_pkg::PH_VER_T1;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VER_T1: begin
                if (c == hrhp_pkg::CH_T) nxt = hrhp_pkg::PH_VER_T2;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VER_T2: begin
                if (c == hrhp_pkg::CH_T) nxt = hrhp_pkg::PH_VER_P;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VER_P: begin
                if (c == hrhp_pkg::CH_P) nxt = hrhp_pkg::PH_VER_SLASH;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_VER_SLASH: begin
                if (c == hrhp_pkg::CH_SLASH) begin
                    major_acc = 0;
                    minor_acc = 0;
                    nxt       = hrhp_pkg::PH_MAJOR_START;
                end else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_MAJOR_START: begin
                if (dig_char(c)) begin
                    major_acc = add_digit(major_acc, c);
                    nxt       = hrhp_pkg::PH_MAJOR;
                end else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_MAJOR: begin
                if (c == hrhp_pkg::CH_DOT) nxt = hrhp_pkg::PH_MINOR_START;
                else if (dig_char(c)) major_acc = add_digit(major_acc, c);
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_MINOR_START: begin
                if (dig_char(c)) begin
                    minor_acc = add_digit(minor_acc, c);
                    nxt       = hrhp_pkg::PH_MINOR;
                end else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_MINOR: begin
                if (c == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_LF1;
                else if (dig_char(c)) minor_acc = add_digit(minor_acc, c);
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_LF1: begin
                if (c == hrhp_pkg::CH_LF) nxt = hrhp_pkg::PH_LINE_START;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_LINE_START: begin
                if (c == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_LF3;
                else if (hdr_seen && (c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_HT))
                    nxt = hrhp_pkg::PH_LWS;
                else if (tok_char(c)) begin
                    hdr_seen = 1'b1;
                    role     = hrhp_pkg::RO_HSTART;
                    nxt      = hrhp_pkg::PH_HNAME;
                end else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_LWS: begin
                if (c == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_LF2;
                else if (c == hrhp_pkg::CH_SP || c == hrhp_pkg::CH_HT) nxt = hrhp_pkg::PH_LWS;
                else if (ctl_char(c)) st = hrhp_pkg::ST_BAD;
                else begin
                    role = hrhp_pkg::RO_HVALUE;
                    nxt  = hrhp_pkg::PH_HVALUE;
                end
            end
            hrhp_pkg::PH_HNAME: begin
                if (c == hrhp_pkg::CH_COLON) nxt = hrhp_pkg::PH_SPACE_BEFORE;
                else if (tok_char(c)) role = hrhp_pkg::RO_HNAME;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_SPACE_BEFORE: begin
                if (c == hrhp_pkg::CH_SP) nxt = hrhp_pkg::PH_HVALUE;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_HVALUE: begin
                if (c == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_LF2;
                else if (ctl_char(c)) st = hrhp_pkg::ST_BAD;
                else role = hrhp_pkg::RO_HVALUE;
            end
            hrhp_pkg::PH_LF2: begin
                if (c == hrhp_pkg::CH_LF) nxt = hrhp_pkg::PH_LINE_START;
                else st = hrhp_pkg::ST_BAD;
            end
            hrhp_pkg::PH_LF3: begin
                st = (c == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_GOOD : hrhp_pkg::ST_BAD;
            end
            default: st = hrhp_pkg::ST_BAD;
        endcase
        // A malformed byte leaves the phase where it was.
        if (st != hrhp_pkg::ST_BAD) phase = nxt;
        r.status        = st;
        r.byte_role     = role;
        r.echo_byte     = c;
        r.major_version = major_acc[7:0];
        r.minor_version = minor_acc[7:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase        = hrhp_pkg::PH_METHOD_START;
            hdr_seen     = 1'b0;
            major_acc    = 0;
            minor_acc    = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result accepted with no request outstanding");
                    o_fail_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("status", int'(oldest.status), int'(i_res.status));
                    check_field("byte_role", int'(oldest.byte_role),
                                int'(i_res.byte_role));
                    check_field("echo_byte", int'(oldest.echo_byte),
                                int'(i_res.echo_byte));
                    check_field("major_version", int'(oldest.major_version),
                                int'(i_res.major_version));
                    check_field("minor_version", int'(oldest.minor_version),
                                int'(i_res.minor_version));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                expected_results = {expected_results, predict_byte(i_req)};
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// HTTP request head parser unit testbench
// Feeds the parser a short directed byte sequence and then a mix of mostly
// well-formed request heads, corrupted heads and raw noise, with bursty
// requests and a receiver that stalls on its own pattern. A checker module
// beside the block predicts and compares every result.
// ============================================================================
module tb;

    // Random part length in request bytes, and the one long receiver hold-off.
    localparam int RANDOM_ITEMS  = 1330;
    localparam int HOLD_AT_ITEM  = 400;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 10;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    hrhp_pkg::t_in  i_req;
    logic           o_valid;
    logic           i_stall;
    hrhp_pkg::t_out o_res;

    int fail_count;
    int pending;

    // Number of request bytes accepted so far; the receiver watches it to
    // place its long hold-off while the sender is busy.
    int sent_count;
    // Requests still to go in the current sender burst.
    int burst_left;
    // Byte sequence being assembled for the next send.
    hrhp_pkg::t_in head_bytes[$];

    string token_set =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&'*+-.^_`|~";

    http_request_head_parser_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    hrhp_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req        (i_req),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("[http_request_head_parser_unit] ERROR");
        $finish;
    end

    // Receiver. It cycles through stall modes of random length: no stall,
    // light random stall, heavy random stall and a fixed periodic pattern.
    // Once, after enough requests have gone in, it holds off for a long
    // stretch so that both internal registers fill and o_stall rises.
    initial begin
        int  mode;
        int  mode_left;
        int  hold_left;
        int  cycle;
        bit  held;
        logic stall_now;
        i_stall   = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        cycle     = 0;
        held      = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle++;
            if (hold_left > 0) begin
                hold_left--;
                stall_now = 1'b1;
            end else if (!held && sent_count >= HOLD_AT_ITEM) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                stall_now = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       stall_now = 1'b0;
                    1:       stall_now = ($urandom_range(0, 3) == 0);
                    2:       stall_now = ($urandom_range(0, 3) != 0);
                    default: stall_now = ((cycle % 7) < 3);
                endcase
            end
            i_stall <= stall_now;
        end
    end

    // Offers one request and returns at the falling edge after it is taken.
    // Bursts of random length are separated by random gaps, some of them
    // empty so that long unbroken runs also occur.
    task automatic send_one(input hrhp_pkg::t_in item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_valid <= 1'b1;
        i_req   <= item;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_head();
        foreach (head_bytes[i]) send_one(head_bytes[i]);
    endtask

    task automatic add_byte(input logic [7:0] b);
        hrhp_pkg::t_in item;
        item.data_byte = b;
        item.restart   = 1'b0;
        head_bytes = {head_bytes, item};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_crlf();
        add_byte(hrhp_pkg::CH_CR);
        add_byte(hrhp_pkg::CH_LF);
    endtask

    task automatic add_digits(input int count);
        repeat (count) add_byte(8'(hrhp_pkg::CH_ZERO + $urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] token_char();
        return token_set[$urandom_range(0, token_set.len() - 1)];
    endfunction

    // A byte that is allowed in a URI or header value; non-ASCII bytes are
    // mixed in so that the top data bit toggles inside well-formed heads.
    function automatic logic [7:0] text_char(input bit allow_space);
        if ($urandom_range(0, 5) == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(allow_space ? 32 : 33, 126));
    endfunction

    function automatic int digit_count();
        // Mostly single digits; now and then enough to saturate.
        return ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : 1;
    endfunction

    function automatic logic [7:0] fold_char();
        return $urandom_range(0, 1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_HT;
    endfunction

    // Builds one well-formed request head with random content: request line,
    // up to three header lines (some of them folded continuations once a
    // header exists) and the closing blank line. The first byte restarts.
    task automatic build_head();
        int lines;
        head_bytes.delete();
        repeat ($urandom_range(1, 4)) add_byte(token_char());
        add_byte(hrhp_pkg::CH_SP);
        repeat ($urandom_range(0, 6)) add_byte(text_char(1'b0));
        add_byte(hrhp_pkg::CH_SP);
        add_text("HTTP/");
        add_digits(digit_count());
        add_byte(hrhp_pkg::CH_DOT);
        add_digits(digit_count());
        add_crlf();
        lines = $urandom_range(0, 3);
        for (int h = 0; h < lines; h++) begin
            if (h > 0 && $urandom_range(0, 2) == 0) begin
                add_byte(fold_char());
                repeat ($urandom_range(0, 2)) add_byte(fold_char());
                repeat ($urandom_range(0, 5)) add_byte(text_char(1'b1));
            end else begin
                repeat ($urandom_range(1, 5)) add_byte(token_char());
                add_byte(hrhp_pkg::CH_COLON);
                add_byte(hrhp_pkg::CH_SP);
                repeat ($urandom_range(0, 6)) add_byte(text_char(1'b1));
            end
            add_crlf();
        end
        add_crlf();
        head_bytes[0].restart = 1'b1;
    endtask

    initial begin
        int item_goal;
        int kind;
        int idx;
        int waited;
        hrhp_pkg::t_in noise;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req      = '0;
        sent_count = 0;
        burst_left = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Extreme bytes at method start are all malformed.
        // Then a minimal head with the highest single version digits, a space
        // at line start before any header (not a continuation, so malformed),
        // the closing blank line, and one byte after completion, which the
        // final line feed phase rejects while holding its phase.
        head_bytes.delete();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(hrhp_pkg::CH_DEL);
        idx = head_bytes.size();
        add_text("A / HTTP/9.9");
        head_bytes[idx].restart = 1'b1;
        add_crlf();
        add_byte(hrhp_pkg::CH_SP);
        add_crlf();
        add_text("x");
        send_head();

        // Random part. Most sequences are well-formed heads; some have one
        // byte replaced and may be cut short after it, some skip the restart
        // so that they land on a finished or broken parse, and the rest is
        // raw noise with random restarts.
        item_goal = sent_count + RANDOM_ITEMS;
        while (sent_count < item_goal) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                build_head();
                if (kind >= 6) begin
                    idx = $urandom_range(0, head_bytes.size() - 1);
                    head_bytes[idx].data_byte = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 0) head_bytes = head_bytes[0:idx];
                end
                if ($urandom_range(0, 9) == 0) head_bytes[0].restart = 1'b0;
            end else begin
                head_bytes.delete();
                repeat ($urandom_range(1, 8)) begin
                    noise.data_byte = 8'($urandom_range(0, 255));
                    noise.restart   = ($urandom_range(0, 3) == 0);
                    head_bytes = {head_bytes, noise};
                end
            end
            send_head();
        end
        i_valid <= 1'b0;

        // Drain: wait for every predicted result, then a few more cycles so
        // that any stray extra result would still be seen.
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[http_request_head_parser_unit] OK");
        end else begin
            $display("[http_request_head_parser_unit] ERROR");
        end
        $finish;
    end

endmodule
